/* src/ssbs_pkg.sv */
// Package for the sorted-set binary search unit: capacity, widths,
// payload structs and status codes. No dependencies.
`default_nettype none

package ssbs_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 16;
  localparam int POS_W    = 10;

  localparam logic [1:0] ST_FOUND   = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_NOSET   = 2'd2;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  typedef struct packed {
    logic                    mode;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [POS_W-1:0] position;
  } out_t;

endpackage

`default_nettype wire

/* src/sorted_set_binary_search_unit.sv */
// Sorted-set binary search unit: load store, in-place bubble sort and
// binary search sharing one element memory. Depends on ssbs_pkg.
`default_nettype none

// Channel  Direction  Handshake             Payload
// in_      input      in_valid / in_ready   in_t  {mode, value, last}
// out_     output     out_valid / out_ready out_t {status, position}
//
// A load marked last then sorts the n stored values in n-1 passes, each one
// sweep through the single memory read port. A search halves its range at each
// step; one with no closed set goes straight to the result. in_ready is low
// while sorting or searching.
// Reset (rst_n, synchronous) empties the set; the memory itself is not cleared.
// A result waiting on out_ready does not block loads; a search holds in its
// last step until the output register frees.

module sorted_set_binary_search_unit
  import ssbs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_SORT_LD  = 9'b000000010,
    S_SORT_LDW = 9'b000000100,
    S_SORT_RD  = 9'b000001000,
    S_SORT_CMP = 9'b000010000,
    S_SORT_WB  = 9'b000100000,
    S_SRCH_CHK = 9'b001000000,
    S_SRCH_CMP = 9'b010000000,
    S_EMIT     = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // set bookkeeping
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             closed_r, closed_nxt;

  // sort sequencer
  logic [ADDR_W-1:0] k_r, k_nxt;
  logic [CNT_W-1:0]  pass_r, pass_nxt;
  logic signed [VAL_W-1:0] carry_r, carry_nxt;

  // search range is [lo, hi1)
  logic [CNT_W-1:0]        lo_r, lo_nxt;
  logic [CNT_W-1:0]        hi1_r, hi1_nxt;
  logic [ADDR_W-1:0]       mid_r, mid_nxt;
  logic signed [VAL_W-1:0] key_r, key_nxt;
  logic [CNT_W:0]          mid_sum;

  out_t res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;

  // element memory
  logic signed [VAL_W-1:0] mem [CAPACITY];
  logic                    we;
  logic [ADDR_W-1:0]       waddr;
  logic signed [VAL_W-1:0] wdata;
  logic [ADDR_W-1:0]       raddr;
  logic signed [VAL_W-1:0] rd_data_r;

  logic              in_xfer;
  logic [CNT_W-1:0]  load_idx;
  logic              load_fits;
  logic [ADDR_W-1:0] last_idx;
  logic              emit_free;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign load_idx  = closed_r ? '0 : count_r;
  assign load_fits = (load_idx < CNT_W'(CAPACITY));
  assign last_idx  = ADDR_W'(count_r - CNT_W'(1));
  assign mid_sum   = ({1'b0, lo_r} + {1'b0, hi1_r}) - (CNT_W+1)'(1);
  assign emit_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    closed_nxt    = closed_r;
    k_nxt         = k_r;
    pass_nxt      = pass_r;
    carry_nxt     = carry_r;
    lo_nxt        = lo_r;
    hi1_nxt       = hi1_r;
    mid_nxt       = mid_r;
    key_nxt       = key_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    we            = 1'b0;
    waddr         = k_r;
    wdata         = carry_r;
    raddr         = ADDR_W'(k_r + ADDR_W'(1));

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_data.mode == MODE_LOAD) begin
            we         = load_fits;
            waddr      = ADDR_W'(load_idx);
            wdata      = in_data.value;
            count_nxt  = load_fits ? load_idx + CNT_W'(1) : load_idx;
            closed_nxt = in_data.last;
            pass_nxt   = '0;
            // a set of one entry needs no sort
            if (in_data.last && (count_nxt > CNT_W'(1))) begin
              state_nxt = S_SORT_LD;
            end
          end else begin
            key_nxt = in_data.value;
            lo_nxt  = '0;
            hi1_nxt = count_r;
            if (closed_r) begin
              state_nxt = S_SRCH_CHK;
            end else begin
              res_nxt   = '{status: ST_NOSET, position: '0};
              state_nxt = S_EMIT;
            end
          end
        end
      end
      S_SORT_LD: begin
        raddr     = '0;
        state_nxt = S_SORT_LDW;
      end
      S_SORT_LDW: begin
        carry_nxt = rd_data_r;
        k_nxt     = '0;
        state_nxt = S_SORT_RD;
      end
      S_SORT_RD: begin
        state_nxt = S_SORT_CMP;
      end
      S_SORT_CMP: begin
        // the larger value bubbles on, the smaller settles at k
        we = 1'b1;
        if (carry_r > rd_data_r) begin
          wdata = rd_data_r;
        end else begin
          wdata     = carry_r;
          carry_nxt = rd_data_r;
        end
        if (CNT_W'(k_r) + CNT_W'(2) == count_r) begin
          state_nxt = S_SORT_WB;
        end else begin
          k_nxt     = k_r + ADDR_W'(1);
          state_nxt = S_SORT_RD;
        end
      end
      S_SORT_WB: begin
        we       = 1'b1;
        waddr    = last_idx;
        pass_nxt = pass_r + CNT_W'(1);
        if (pass_nxt == count_r - CNT_W'(1)) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_SORT_LD;
        end
      end
      S_SRCH_CHK: begin
        mid_nxt = ADDR_W'(mid_sum >> 1);
        raddr   = mid_nxt;
        if (lo_r >= hi1_r) begin
          res_nxt   = '{status: ST_MISSING, position: '0};
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (key_r == rd_data_r) begin
          res_nxt   = '{status: ST_FOUND, position: POS_W'(mid_r)};
          state_nxt = S_EMIT;
        end else begin
          if (key_r < rd_data_r) begin
            hi1_nxt = CNT_W'(mid_r);
          end else begin
            lo_nxt = CNT_W'(mid_r) + CNT_W'(1);
          end
          state_nxt = S_SRCH_CHK;
        end
      end
      S_EMIT: begin
        if (emit_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      closed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      closed_r    <= closed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    pass_r     <= pass_nxt;
    carry_r    <= carry_nxt;
    lo_r       <= lo_nxt;
    hi1_r      <= hi1_nxt;
    mid_r      <= mid_nxt;
    key_r      <= key_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // searching only ever runs over a closed set
  a_search_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH_CHK || state_r == S_SRCH_CMP) |-> closed_r)
    else $error("search running without a closed set");

  // a compare step always follows a non-empty range
  a_range_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH_CMP) |-> (lo_r < hi1_r))
    else $error("search compare on an empty range");

  // the sort only runs with at least two entries
  a_sort_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SORT_LD || state_r == S_SORT_LDW || state_r == S_SORT_RD ||
     state_r == S_SORT_CMP || state_r == S_SORT_WB) |-> (count_r > CNT_W'(1)))
    else $error("sort running on fewer than two entries");

  // a search transfer goes straight to the search or to the result
  a_search_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_data.mode == MODE_SEARCH) |=>
    (state_r == S_SRCH_CHK || state_r == S_EMIT))
    else $error("search transfer did not start a search");

endmodule

`default_nettype wire
